// ===== src/ddstw_pkg.sv =====
`default_nettype none
package ddstw_pkg;

   localparam int FREQ_BITS       = 26;
   localparam int REFCLK_BITS     = 27;
   localparam int TUNING_BITS     = 32;
   localparam int WORD_FRAME_BITS = 32;
   localparam int CTRL_BITS       = 8;
   localparam int FRAME_BITS      = WORD_FRAME_BITS + CTRL_BITS;
   localparam int POS_BITS        = 6;
   localparam int REQ_TDATA_BITS  = 32;
   localparam int RSP_TDATA_BITS  = 8;

   // one quotient bit per step over the whole shifted dividend
   localparam int DIV_STEPS = FREQ_BITS + TUNING_BITS;
   localparam int CNT_BITS  = $clog2(DIV_STEPS);

   localparam logic [CTRL_BITS-1:0]   CTRL_SQUARE  = 8'h01;
   localparam logic [CTRL_BITS-1:0]   CTRL_SINE    = 8'h00;
   localparam logic [REFCLK_BITS-1:0] REFCLK_RESET = 27'd125000000;
   localparam logic [POS_BITS-1:0]    LAST_POS     = POS_BITS'(FRAME_BITS - 1);

   typedef struct packed {
      logic                   done;
      logic [TUNING_BITS-1:0] quotient;
   } div_result_type;

   // low word of the tuning word (zero padded or truncated), control byte on top
   function automatic logic [FRAME_BITS-1:0] build_frame(
      input logic [TUNING_BITS-1:0] quotient,
      input logic                   square
   );
      logic [63:0]          q_ext;
      logic [CTRL_BITS-1:0] ctrl;
      q_ext = 64'(quotient);
      ctrl  = square ? CTRL_SQUARE : CTRL_SINE;
      return {ctrl, q_ext[WORD_FRAME_BITS-1:0]};
   endfunction

endpackage
`default_nettype wire

// ===== src/ddstw_divider.sv =====
`default_nettype none
module ddstw_divider
   import ddstw_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [FREQ_BITS-1:0]   dividend,
   input  wire logic [REFCLK_BITS-1:0] divisor,
   output div_result_type              result
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [FREQ_BITS-1:0]   num_ff, num_in;
   logic [REFCLK_BITS-1:0] rem_ff, rem_in;
   logic [TUNING_BITS-1:0] quo_ff, quo_in;

   logic [REFCLK_BITS:0]   trial;
   logic [REFCLK_BITS:0]   diff;
   logic                   fits;

   // shift in the next dividend bit, zeros once the frequency bits are used up
   assign trial = {rem_ff, num_ff[FREQ_BITS-1]};
   assign fits  = trial >= {1'b0, divisor};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_BITS'(DIV_STEPS - 1);
         num_in   = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[FREQ_BITS-2:0], 1'b0};
         rem_in = fits ? diff[REFCLK_BITS-1:0] : trial[REFCLK_BITS-1:0];
         quo_in = {quo_ff[TUNING_BITS-2:0], fits};
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
   end

   assign result.done     = done_ff;
   assign result.quotient = quo_ff;

endmodule
`default_nettype wire

// ===== src/ddstw_serializer.sv =====
`default_nettype none
module ddstw_serializer
   import ddstw_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      load,
   input  wire logic [FRAME_BITS-1:0]     frame,
   output      logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   output      logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   output      logic                      rsp_tlast
);

   logic                  valid_ff, valid_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [FRAME_BITS-1:0] shift_ff, shift_in;
   logic                  last;

   assign last = pos_ff == LAST_POS;

   always_comb begin
      valid_in = valid_ff;
      pos_in   = pos_ff;
      shift_in = shift_ff;
      if (load) begin
         valid_in = 1'b1;
         pos_in   = '0;
         shift_in = frame;
      end else if (valid_ff && rsp_tready) begin
         if (last) begin
            valid_in = 1'b0;
         end else begin
            pos_in   = pos_ff + 1'b1;
            shift_in = {1'b0, shift_ff[FRAME_BITS-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
      shift_ff <= shift_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, pos_ff, shift_ff[0]};
   assign rsp_tlast  = last;

endmodule
`default_nettype wire

// ===== src/dds_tuning_word_serial_loader_top.sv =====
// Flow: once the request beat is accepted, the divider runs its 58 steps, one quotient
//   bit each, and the frame is then loaded into the output register.
// A new request is taken only in idle, after the last of the 40 bit beats is taken;
//   each bit beat can be held back by rsp_tready low.
// Reset: synchronous, active high; clears the sequencer and output valid and sets
//   the reference clock register to 125000000.
`default_nettype none
module dds_tuning_word_serial_loader_top
   import ddstw_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   // configuration: reference clock in hertz
   input  wire logic                      csr_write_enable,
   input  wire logic [REFCLK_BITS-1:0]    csr_write_data,
   // request channel
   input  wire logic                      req_tvalid,
   output      logic                      req_tready,
   input  wire logic [REQ_TDATA_BITS-1:0] req_tdata,  // [25:0] frequency_hz, [31:26] zero
   input  wire logic                      req_tuser,  // [0] square_select
   // response channel, one beat per serial bit
   output      logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   output      logic [RSP_TDATA_BITS-1:0] rsp_tdata,  // [0] serial_bit, [6:1] bit_position,
                                                      // [7] zero
   output      logic                      rsp_tlast   // load_strobe
);

   // one-hot sequencer: wait for a request, run the divider, send the frame
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_SEND   = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [REFCLK_BITS-1:0] refclk_ff, refclk_in;
   logic                   square_ff, square_in;

   logic                   req_beat;
   logic                   last_beat;
   logic                   load;
   div_result_type         div_result;
   logic [FRAME_BITS-1:0]  frame;

   assign req_tready = state_ff == ST_IDLE;
   assign req_beat   = req_tvalid && req_tready;
   assign last_beat  = rsp_tvalid && rsp_tready && rsp_tlast;

   // hold the reference clock; the user must write it only while the block is idle (not enforced here)
   assign refclk_in = csr_write_enable ? csr_write_data : refclk_ff;

   // hold the waveform select of the accepted request until the frame is built
   assign square_in = req_beat ? req_tuser : square_ff;

   always_comb begin
      state_in = state_ff;
      load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // divider result is ready: load the frame into the serializer
            if (div_result.done) begin
               load     = 1'b1;
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            // drop back to idle once the strobe beat is taken
            if (last_beat) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         refclk_ff <= REFCLK_RESET;
      end else begin
         state_ff  <= state_in;
         refclk_ff <= refclk_in;
      end
      square_ff <= square_in;
   end

   // restoring divider: frequency * 2^TUNING_BITS / reference clock
   ddstw_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (req_beat),
      .dividend (req_tdata[FREQ_BITS-1:0]),
      .divisor  (refclk_ff),
      .result   (div_result)
   );

   // tuning word low byte first, control byte last
   assign frame = build_frame(div_result.quotient, square_ff);

   // LSB-first bit serializer with registered output
   ddstw_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .frame      (frame),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// ===== tb/tb_dds_tuning_word_serial_loader_top.sv =====
`timescale 1ns / 100ps
module tb_dds_tuning_word_serial_loader_top
   import ddstw_pkg::*;
();

   // receiver hold-off long enough to back the block up into its request port
   localparam int HOLDOFF_CYCLES = 600;
   // settle time after the last bit beat: well over the first-bit latency
   localparam int TAIL_CYCLES    = 120;
   localparam int REPORT_LIMIT   = 10;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   // one frequency load: what the request channel carries
   typedef struct packed {
      logic [FREQ_BITS-1:0] freq_hz;
      logic                 square;
   } freq_load_type;

   // one serial bit as it should leave the block
   typedef struct packed {
      logic                serial_bit;
      logic [POS_BITS-1:0] position;
      logic                strobe;
   } bit_beat_type;

   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      csr_write_enable = 1'b0;
   logic [REFCLK_BITS-1:0]    csr_write_data   = '0;
   logic                      req_tvalid       = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata        = '0;  // [25:0] frequency_hz, [31:26] zero
   logic                      req_tuser        = 1'b0; // [0] square_select
   logic                      rsp_tvalid;
   logic                      rsp_tready       = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;  // [0] serial_bit, [6:1] bit_position, [7] zero
   logic                      rsp_tlast;  // load_strobe

   freq_load_type          load_requests[$];   // loads waiting for the driver
   bit_beat_type           bit_beats_due[$];   // serial bits predicted, oldest first
   logic [REFCLK_BITS-1:0] ref_clock_hz = REFCLK_RESET;
   idle_mode_type          idle_mode    = IDLE_NONE;
   bit                     req_beat_taken = 1'b0;
   bit                     holdoff_armed  = 1'b0;
   int unsigned            holdoff_left   = 0;
   int unsigned            mismatch_count = 0;

   dds_tuning_word_serial_loader_top u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tlast        (rsp_tlast)
   );

   always #1 clock = ~clock;

   // Tuning word: floor(freq * 2^32 / refclk), low 32 bits kept. A zero divisor
   // lets the restoring divider subtract every step, so the word is all ones.
   function automatic logic [31:0] tuning_word_for(input logic [FREQ_BITS-1:0] freq_hz,
                                                   input logic [REFCLK_BITS-1:0] refclk);
      logic [63:0] dividend;
      logic [63:0] quotient;
      dividend = {6'd0, freq_hz, 32'd0};
      if (refclk == '0)
         return 32'hFFFF_FFFF;
      quotient = dividend / {37'd0, refclk};
      return quotient[31:0];
   endfunction

   // Queue the 40 bits of one load: word low byte first, control byte last,
   // each byte least significant bit first, strobe on the final bit.
   task automatic predict_load_bits(input freq_load_type load);
      logic [FRAME_BITS-1:0] frame;
      bit_beat_type          beat;
      frame = {(load.square ? CTRL_SQUARE : CTRL_SINE),
               tuning_word_for(load.freq_hz, ref_clock_hz)};
      for (int k = 0; k < FRAME_BITS; k++) begin
         beat.serial_bit = frame[k];
         beat.position   = POS_BITS'(k);
         beat.strobe     = (k == FRAME_BITS - 1);
         bit_beats_due.push_back(beat);
      end
   endtask

   task automatic report_mismatch(input string field, input int unsigned want,
                                  input int unsigned got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
   endtask

   function automatic bit rests_now(input bit receiver_side);
      int unsigned pct;
      case (idle_mode)
         IDLE_SENDER:   pct = receiver_side ? 0 : 88;
         IDLE_RECEIVER: pct = receiver_side ? 88 : 0;
         IDLE_BOTH:     pct = 26;
         default:       pct = 0;
      endcase
      return $urandom_range(0, 99) < pct;
   endfunction

   // Request driver: advance to the next load only once the current beat is taken.
   always @(negedge clock) begin : drive_requests
      freq_load_type next_load;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_beat_taken) begin
         req_beat_taken = 1'b0;
         if (load_requests.size() != 0 && !rests_now(1'b0)) begin
            next_load = load_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= REQ_TDATA_BITS'(next_load.freq_hz);
            req_tuser  <= next_load.square;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response ready: random stalls per mode, or a long hold-off when armed.
   always @(negedge clock) begin
      if (holdoff_armed) begin
         holdoff_left  = HOLDOFF_CYCLES;
         holdoff_armed = 1'b0;
      end
      if (holdoff_left != 0) begin
         holdoff_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !rests_now(1'b1);
      end
   end

   // Monitor: predict on each accepted request beat, check each bit beat in order.
   always @(posedge clock) begin : watch_beats
      bit_beat_type  due;
      freq_load_type taken;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            taken.freq_hz = req_tdata[FREQ_BITS-1:0];
            taken.square  = req_tuser;
            predict_load_bits(taken);
            req_beat_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (bit_beats_due.size() == 0) begin
               report_mismatch("unexpected bit beat (tdata)", 0, 32'(rsp_tdata));
            end else begin
               due = bit_beats_due.pop_front();
               if (rsp_tdata[0] !== due.serial_bit)
                  report_mismatch("serial_bit", 32'(due.serial_bit), 32'(rsp_tdata[0]));
               if (rsp_tdata[6:1] !== due.position)
                  report_mismatch("bit_position", 32'(due.position), 32'(rsp_tdata[6:1]));
               if (rsp_tlast !== due.strobe)
                  report_mismatch("load_strobe", 32'(due.strobe), 32'(rsp_tlast));
               if (rsp_tdata[7] !== 1'b0)
                  report_mismatch("tdata pad bit", 0, 32'(rsp_tdata[7]));
            end
         end
      end
   end

   task automatic queue_load(input logic [FREQ_BITS-1:0] freq_hz, input logic square);
      freq_load_type load;
      load.freq_hz = freq_hz;
      load.square  = square;
      load_requests.push_back(load);
   endtask

   // Mix of in-range, full-field and tiny frequencies; square select random.
   task automatic queue_random_loads(input int count);
      logic [FREQ_BITS-1:0] freq_hz;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 3))
            0, 1:    freq_hz = FREQ_BITS'($urandom_range(0, 62500000));
            2:       freq_hz = FREQ_BITS'($urandom);
            default: freq_hz = FREQ_BITS'($urandom_range(0, 2000));
         endcase
         queue_load(freq_hz, 1'($urandom_range(0, 1)));
      end
   endtask

   // Wait until every load is taken and every bit beat has arrived.
   task automatic settle();
      while (load_requests.size() != 0 || req_tvalid || bit_beats_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write the reference clock while the block is idle; mirror it for prediction.
   task automatic write_ref_clock(input logic [REFCLK_BITS-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      ref_clock_hz = value;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset reference clock: field extremes, both waveforms, alternating bits.
      idle_mode = IDLE_NONE;
      queue_load(26'd0, 1'b0);
      queue_load(26'd0, 1'b1);
      queue_load(26'd1, 1'b0);
      queue_load(26'd62500000, 1'b1);
      queue_load(26'h3FF_FFFF, 1'b0);
      queue_load(26'h2AA_AAAA, 1'b1);
      queue_load(26'h155_5555, 1'b0);
      queue_load(26'd31250000, 1'b1);
      settle();

      // Smallest divisor: the quotient is freq << 32, so the kept word wraps to zero.
      write_ref_clock(27'd1);
      queue_load(26'd0, 1'b1);
      queue_load(26'd1, 1'b0);
      queue_load(26'h3FF_FFFF, 1'b1);
      settle();

      // Zero divisor: the word comes out all ones.
      write_ref_clock(27'd0);
      queue_load(26'd0, 1'b0);
      queue_load(26'd12345, 1'b1);
      queue_load(26'h3FF_FFFF, 1'b0);
      settle();

      // Largest register value, sender idling.
      write_ref_clock(27'h7FF_FFFF);
      idle_mode = IDLE_SENDER;
      queue_load(26'h3FF_FFFF, 1'b1);
      queue_random_loads(85);
      settle();

      // Small divisor: frequency at or above it wraps the quotient; receiver stalling.
      write_ref_clock(27'd1000);
      idle_mode = IDLE_RECEIVER;
      queue_load(26'd1000, 1'b0);
      queue_load(26'd999, 1'b1);
      queue_load(26'd1001, 1'b0);
      queue_random_loads(85);
      settle();

      // Reset value of the reference clock, both sides idling.
      write_ref_clock(27'd125000000);
      idle_mode = IDLE_BOTH;
      queue_random_loads(85);
      settle();

      // Random divisor, no idling; hold off the receiver so requests back up.
      write_ref_clock(REFCLK_BITS'($urandom_range(1, 125000000)));
      idle_mode = IDLE_NONE;
      queue_random_loads(85);
      holdoff_armed = 1'b1;
      settle();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && bit_beats_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog: several times the slowest legal run.
   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== dds_tuning_word_serial_loader_top.f =====
src/ddstw_pkg.sv
src/ddstw_divider.sv
src/ddstw_serializer.sv
src/dds_tuning_word_serial_loader_top.sv
tb/tb_dds_tuning_word_serial_loader_top.sv
